>>> src/c2e_pkg.sv
`default_nettype none
package c2e_pkg;

    localparam int unsigned PIX_W    = 15;
    localparam int unsigned CFG_W    = 15;
    localparam int unsigned FSIZE_W  = 13;
    localparam int unsigned COORD_W  = 13;
    localparam int unsigned MAG_W    = 31;
    localparam int unsigned TRIG_W   = 32;
    localparam int unsigned DEN_W    = 32;
    localparam int unsigned PROD_W   = 45;
    localparam int unsigned HORNER_N = 4;
    localparam int unsigned LANES    = 4;

    localparam logic [MAG_W-1:0] Q_ONE   = 31'h4000_0000;
    localparam logic [MAG_W-1:0] POLY_C9 = 31'd172272;
    localparam logic [MAG_W-1:0] POLY_C [HORNER_N] = '{
        31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
    };

    localparam logic [CFG_W-1:0]   RST_OUT_WIDTH   = 15'd24000;
    localparam logic [CFG_W-1:0]   RST_OUT_HEIGHT  = 15'd12000;
    localparam logic [FSIZE_W-1:0] RST_FACE_WIDTH  = 13'd1024;
    localparam logic [FSIZE_W-1:0] RST_FACE_HEIGHT = 13'd1024;

    typedef enum logic [1:0] {
        CFG_OUT_WIDTH   = 2'd0,
        CFG_OUT_HEIGHT  = 2'd1,
        CFG_FACE_WIDTH  = 2'd2,
        CFG_FACE_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FACE_RIGHT  = 3'd0,
        FACE_LEFT   = 3'd1,
        FACE_TOP    = 3'd2,
        FACE_BOTTOM = 3'd3,
        FACE_FRONT  = 3'd4,
        FACE_BACK   = 3'd5
    } t_face;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_phi;
        logic signed [TRIG_W-1:0] cos_phi;
        logic signed [TRIG_W-1:0] cos_theta;
        logic signed [TRIG_W-1:0] sin_theta;
    } t_trig;

    typedef struct packed {
        t_face face;
        logic  null_dir;
    } t_proj_side;

endpackage
`default_nettype wire

>>> src/c2e_pix_if.sv
`default_nettype none
interface c2e_pix_if;
    logic                       valid;
    logic                       ready;
    logic [c2e_pkg::PIX_W-1:0]  out_x;
    logic [c2e_pkg::PIX_W-1:0]  out_y;

    modport source(output valid, output out_x, output out_y, input ready);
    modport sink(input valid, input out_x, input out_y, output ready);
endinterface
`default_nettype wire

>>> src/c2e_map_if.sv
`default_nettype none
interface c2e_map_if;
    logic                         valid;
    logic                         ready;
    c2e_pkg::t_face               face;
    logic [c2e_pkg::COORD_W-1:0]  face_u;
    logic [c2e_pkg::COORD_W-1:0]  face_v;
    logic                         in_range;

    modport source(output valid, output face, output face_u, output face_v,
                   output in_range, input ready);
    modport sink(input valid, input face, input face_u, input face_v,
                 input in_range, output ready);
endinterface
`default_nettype wire

>>> src/c2e_angle.sv
`default_nettype none
module c2e_angle #(
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [c2e_pkg::PIX_W-1:0]   i_x,
    input  wire logic [c2e_pkg::PIX_W-1:0]   i_y,
    input  wire logic [c2e_pkg::PIX_W-1:0]   i_den_x,
    input  wire logic [c2e_pkg::PIX_W-1:0]   i_den_y,
    output logic                             o_valid,
    output logic [ANGLE_FRAC_BITS-1:0]       o_theta,
    output logic [ANGLE_FRAC_BITS-1:0]       o_phi_raw
);
    localparam int unsigned A     = ANGLE_FRAC_BITS;
    localparam int unsigned RW    = c2e_pkg::PIX_W;
    localparam int unsigned STEPS = c2e_pkg::PIX_W + ANGLE_FRAC_BITS;

    logic [RW-1:0]    p_xrem [STEPS];
    logic [STEPS-1:0] p_xbit [STEPS];
    logic [A-1:0]     p_xq   [STEPS];
    logic [RW-1:0]    p_yrem [STEPS];
    logic [STEPS-1:0] p_ybit [STEPS];
    logic [A-1:0]     p_yq   [STEPS];
    logic             p_v    [STEPS];

    logic [RW-1:0]    r_xrem [STEPS];
    logic [STEPS-1:0] r_xbit [STEPS];
    logic [A-1:0]     r_xq   [STEPS];
    logic [RW-1:0]    r_yrem [STEPS];
    logic [STEPS-1:0] r_ybit [STEPS];
    logic [A-1:0]     r_yq   [STEPS];
    logic             r_v    [STEPS];

    assign p_xrem[0] = '0;
    assign p_xbit[0] = {i_x, {A{1'b0}}};
    assign p_xq[0]   = '0;
    assign p_yrem[0] = '0;
    assign p_ybit[0] = {1'b0, i_y, {(A-1){1'b0}}};
    assign p_yq[0]   = '0;
    assign p_v[0]    = i_valid;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [RW:0] xt;
        logic [RW:0] yt;
        logic        xge;
        logic        yge;

        if (k > 0) begin : g_link
            assign p_xrem[k] = r_xrem[k-1];
            assign p_xbit[k] = r_xbit[k-1];
            assign p_xq[k]   = r_xq[k-1];
            assign p_yrem[k] = r_yrem[k-1];
            assign p_ybit[k] = r_ybit[k-1];
            assign p_yq[k]   = r_yq[k-1];
            assign p_v[k]    = r_v[k-1];
        end

        assign xt  = {p_xrem[k], p_xbit[k][STEPS-1]};
        assign yt  = {p_yrem[k], p_ybit[k][STEPS-1]};
        assign xge = xt >= {1'b0, i_den_x};
        assign yge = yt >= {1'b0, i_den_y};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xrem[k] <= xge ? RW'(xt - {1'b0, i_den_x}) : RW'(xt);
                r_yrem[k] <= yge ? RW'(yt - {1'b0, i_den_y}) : RW'(yt);
                r_xbit[k] <= p_xbit[k] << 1;
                r_ybit[k] <= p_ybit[k] << 1;
                r_xq[k]   <= {p_xq[k][A-2:0], xge};
                r_yq[k]   <= {p_yq[k][A-2:0], yge};
            end
        end
    end

    assign o_valid   = r_v[STEPS-1];
    assign o_theta   = r_xq[STEPS-1];
    assign o_phi_raw = r_yq[STEPS-1];
endmodule
`default_nettype wire

>>> src/c2e_trig.sv
`default_nettype none
module c2e_trig #(
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [ANGLE_FRAC_BITS-1:0]  i_theta,
    input  wire logic [ANGLE_FRAC_BITS-1:0]  i_phi_raw,
    output logic                             o_valid,
    output c2e_pkg::t_trig                   o_trig
);
    localparam int unsigned A  = ANGLE_FRAC_BITS;
    localparam int unsigned MW = c2e_pkg::MAG_W;
    localparam int unsigned HN = c2e_pkg::HORNER_N;
    localparam int unsigned NL = c2e_pkg::LANES;
    localparam logic [A-1:0] QUARTER = {2'b01, {(A-2){1'b0}}};

    logic [A-1:0]                     ang  [NL];
    logic [MW-1:0]                    r_x  [HN+1][NL];
    logic [1:0]                       r_q  [HN+1][NL];
    logic [MW-1:0]                    r_x2 [HN+1][NL];
    logic [MW-1:0]                    r_p  [HN+1][NL];
    logic signed [c2e_pkg::TRIG_W-1:0] r_s [NL];
    logic                             r_v  [HN+2];

    // Lanes: sin phi, cos phi, cos theta, sin theta. The phi input still
    // carries the quarter-turn offset, which makes it the cosine angle.
    assign ang[0] = i_phi_raw - QUARTER;
    assign ang[1] = i_phi_raw;
    assign ang[2] = i_theta + QUARTER;
    assign ang[3] = i_theta;

    for (genvar l = 0; l < NL; l++) begin : g_lane
        logic [1:0]      quad;
        logic [MW-2:0]   off;
        logic [MW-1:0]   x0;
        logic [2*MW-1:0] sq;
        logic [2*MW-1:0] sp;
        logic [31:0]     smag;

        assign quad = ang[l][A-1 -: 2];
        assign off  = {ang[l][A-3:0], {(32-A){1'b0}}};
        assign x0   = quad[0] ? c2e_pkg::Q_ONE - {1'b0, off} : {1'b0, off};
        assign sq   = x0 * x0;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0][l]  <= x0;
                r_q[0][l]  <= quad;
                r_x2[0][l] <= sq[60:30];
                r_p[0][l]  <= c2e_pkg::POLY_C9;
            end
        end

        for (genvar j = 1; j <= HN; j++) begin : g_horner
            logic [2*MW-1:0] hp;

            assign hp = r_x2[j-1][l] * r_p[j-1][l];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[j][l]  <= r_x[j-1][l];
                    r_q[j][l]  <= r_q[j-1][l];
                    r_x2[j][l] <= r_x2[j-1][l];
                    r_p[j][l]  <= MW'(c2e_pkg::POLY_C[j-1] - hp[61:30]);
                end
            end
        end

        assign sp   = r_x[HN][l] * r_p[HN][l];
        assign smag = (sp[61:30] > 32'(c2e_pkg::Q_ONE)) ? 32'(c2e_pkg::Q_ONE) : sp[61:30];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[l] <= r_q[HN][l][1] ? -smag : smag;
            end
        end
    end

    assign r_v[0] = i_valid;

    for (genvar j = 1; j < HN + 2; j++) begin : g_valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[HN+1];
        end
    end

    assign o_trig.sin_phi   = r_s[0];
    assign o_trig.cos_phi   = r_s[1];
    assign o_trig.cos_theta = r_s[2];
    assign o_trig.sin_theta = r_s[3];
endmodule
`default_nettype wire

>>> src/c2e_proj.sv
`default_nettype none
module c2e_proj (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire c2e_pkg::t_proj_side          i_side,
    input  wire logic [c2e_pkg::DEN_W-1:0]    i_den,
    input  wire logic [c2e_pkg::PROD_W-1:0]   i_prod_u,
    input  wire logic [c2e_pkg::PROD_W-1:0]   i_prod_v,
    output logic                              o_valid,
    output c2e_pkg::t_proj_side               o_side,
    output logic [c2e_pkg::COORD_W-1:0]       o_quo_u,
    output logic [c2e_pkg::COORD_W-1:0]       o_quo_v
);
    localparam int unsigned DW    = c2e_pkg::DEN_W;
    localparam int unsigned STEPS = c2e_pkg::COORD_W;

    logic [DW-1:0]       p_urem [STEPS];
    logic [STEPS-1:0]    p_ubit [STEPS];
    logic [DW-1:0]       p_vrem [STEPS];
    logic [STEPS-1:0]    p_vbit [STEPS];
    logic [STEPS-1:0]    p_uq   [STEPS];
    logic [STEPS-1:0]    p_vq   [STEPS];
    logic [DW-1:0]       p_den  [STEPS];
    c2e_pkg::t_proj_side p_side [STEPS];
    logic                p_v    [STEPS];

    logic [DW-1:0]       r_urem [STEPS];
    logic [STEPS-1:0]    r_ubit [STEPS];
    logic [DW-1:0]       r_vrem [STEPS];
    logic [STEPS-1:0]    r_vbit [STEPS];
    logic [STEPS-1:0]    r_uq   [STEPS];
    logic [STEPS-1:0]    r_vq   [STEPS];
    logic [DW-1:0]       r_den  [STEPS];
    c2e_pkg::t_proj_side r_side [STEPS];
    logic                r_v    [STEPS];

    assign p_urem[0] = i_prod_u[c2e_pkg::PROD_W-1 -: DW];
    assign p_ubit[0] = i_prod_u[STEPS-1:0];
    assign p_vrem[0] = i_prod_v[c2e_pkg::PROD_W-1 -: DW];
    assign p_vbit[0] = i_prod_v[STEPS-1:0];
    assign p_uq[0]   = '0;
    assign p_vq[0]   = '0;
    assign p_den[0]  = i_den;
    assign p_side[0] = i_side;
    assign p_v[0]    = i_valid;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DW:0] ut;
        logic [DW:0] vt;
        logic        uge;
        logic        vge;

        if (k > 0) begin : g_link
            assign p_urem[k] = r_urem[k-1];
            assign p_ubit[k] = r_ubit[k-1];
            assign p_vrem[k] = r_vrem[k-1];
            assign p_vbit[k] = r_vbit[k-1];
            assign p_uq[k]   = r_uq[k-1];
            assign p_vq[k]   = r_vq[k-1];
            assign p_den[k]  = r_den[k-1];
            assign p_side[k] = r_side[k-1];
            assign p_v[k]    = r_v[k-1];
        end

        assign ut  = {p_urem[k], p_ubit[k][STEPS-1]};
        assign vt  = {p_vrem[k], p_vbit[k][STEPS-1]};
        assign uge = ut >= {1'b0, p_den[k]};
        assign vge = vt >= {1'b0, p_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_urem[k] <= uge ? DW'(ut - {1'b0, p_den[k]}) : DW'(ut);
                r_vrem[k] <= vge ? DW'(vt - {1'b0, p_den[k]}) : DW'(vt);
                r_ubit[k] <= p_ubit[k] << 1;
                r_vbit[k] <= p_vbit[k] << 1;
                r_uq[k]   <= {p_uq[k][STEPS-2:0], uge};
                r_vq[k]   <= {p_vq[k][STEPS-2:0], vge};
                r_den[k]  <= p_den[k];
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_side  = r_side[STEPS-1];
    assign o_quo_u = r_uq[STEPS-1];
    assign o_quo_v = r_vq[STEPS-1];
endmodule
`default_nettype wire

>>> src/cubemap_to_equirect_lookup_core.sv
// Throughput: one transfer per cycle; the angle dividers, the sine polynomial
// lanes and the projection dividers are fully pipelined, one step per stage.
// A result held at the output freezes the whole pipeline until it is taken.
// Reset clears all valid bits and loads the default panorama and face sizes.
`default_nettype none
module cubemap_to_equirect_lookup_core #(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned FACE_COORD_BITS = 13
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    c2e_pix_if.sink                          i_pix,
    c2e_map_if.source                        o_map,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [c2e_pkg::CFG_W-1:0]   i_cfg_data
);
    localparam int unsigned A         = ANGLE_FRAC_BITS;
    localparam int unsigned COORD_MAX = (1 << FACE_COORD_BITS) - 1;
    localparam int unsigned FW        = c2e_pkg::FSIZE_W;
    localparam int unsigned TW        = c2e_pkg::TRIG_W;

    logic [c2e_pkg::CFG_W-1:0] r_out_width;
    logic [c2e_pkg::CFG_W-1:0] r_out_height;
    logic [FW-1:0]             r_face_width;
    logic [FW-1:0]             r_face_height;
    logic [c2e_pkg::CFG_W-1:0] den_x;
    logic [c2e_pkg::CFG_W-1:0] den_y;
    logic                      en;

    logic                      ang_v;
    logic [A-1:0]              ang_theta;
    logic [A-1:0]              ang_phi;
    logic                      trig_v;
    c2e_pkg::t_trig            trig;

    logic                      r_q_v;
    logic signed [TW-1:0]      r_sx;
    logic signed [TW-1:0]      r_sy;
    logic signed [TW-1:0]      r_sz;

    logic [c2e_pkg::MAG_W-1:0] ax;
    logic [c2e_pkg::MAG_W-1:0] ay;
    logic [c2e_pkg::MAG_W-1:0] az;
    logic signed [TW-1:0]      sel_d;
    logic signed [TW-1:0]      sel_nu;
    logic signed [TW-1:0]      sel_nv;
    c2e_pkg::t_face            sel_face;

    logic                          r_f_v;
    c2e_pkg::t_proj_side           r_f_side;
    logic [c2e_pkg::DEN_W-1:0]     r_f_den;
    logic [TW-1:0]                 r_f_num_u;
    logic [TW-1:0]                 r_f_num_v;

    logic                          r_m_v;
    c2e_pkg::t_proj_side           r_m_side;
    logic [c2e_pkg::DEN_W-1:0]     r_m_den;
    logic [c2e_pkg::PROD_W-1:0]    r_m_prod_u;
    logic [c2e_pkg::PROD_W-1:0]    r_m_prod_v;

    logic                          pj_v;
    c2e_pkg::t_proj_side           pj_side;
    logic [c2e_pkg::COORD_W-1:0]   pj_u;
    logic [c2e_pkg::COORD_W-1:0]   pj_v_quo;
    logic [c2e_pkg::COORD_W-1:0]   fin_u;
    logic [c2e_pkg::COORD_W-1:0]   fin_v;
    logic                          fin_ok;

    logic                          r_o_valid;
    c2e_pkg::t_face                r_o_face;
    logic [c2e_pkg::COORD_W-1:0]   r_o_u;
    logic [c2e_pkg::COORD_W-1:0]   r_o_v;
    logic                          r_o_ok;

    function automatic logic signed [TW-1:0] qmul(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic [c2e_pkg::MAG_W-1:0]   ma;
        logic [c2e_pkg::MAG_W-1:0]   mb;
        logic [2*c2e_pkg::MAG_W-1:0] m;
        logic [TW-1:0]               r;
        ma = a[TW-1] ? c2e_pkg::MAG_W'(-a) : a[c2e_pkg::MAG_W-1:0];
        mb = b[TW-1] ? c2e_pkg::MAG_W'(-b) : b[c2e_pkg::MAG_W-1:0];
        m  = ma * mb;
        r  = {1'b0, m[60:30]};
        return (a[TW-1] ^ b[TW-1]) ? -r : r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width   <= c2e_pkg::RST_OUT_WIDTH;
            r_out_height  <= c2e_pkg::RST_OUT_HEIGHT;
            r_face_width  <= c2e_pkg::RST_FACE_WIDTH;
            r_face_height <= c2e_pkg::RST_FACE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (c2e_pkg::t_cfg_idx'(i_cfg_idx))
                c2e_pkg::CFG_OUT_WIDTH:   r_out_width   <= i_cfg_data;
                c2e_pkg::CFG_OUT_HEIGHT:  r_out_height  <= i_cfg_data;
                c2e_pkg::CFG_FACE_WIDTH:  r_face_width  <= FW'(i_cfg_data);
                c2e_pkg::CFG_FACE_HEIGHT: r_face_height <= FW'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign den_x = (r_out_width == '0) ? c2e_pkg::CFG_W'(1) : r_out_width;
    assign den_y = (r_out_height == '0) ? c2e_pkg::CFG_W'(1) : r_out_height;

    assign en          = !r_o_valid || o_map.ready;
    assign i_pix.ready = en;

    c2e_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_angle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_pix.valid),
        .i_x       (i_pix.out_x),
        .i_y       (i_pix.out_y),
        .i_den_x   (den_x),
        .i_den_y   (den_y),
        .o_valid   (ang_v),
        .o_theta   (ang_theta),
        .o_phi_raw (ang_phi)
    );

    c2e_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (ang_v),
        .i_theta   (ang_theta),
        .i_phi_raw (ang_phi),
        .o_valid   (trig_v),
        .o_trig    (trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (en) begin
            r_q_v <= trig_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx <= qmul(trig.cos_phi, trig.cos_theta);
            r_sy <= trig.sin_phi;
            r_sz <= qmul(trig.cos_phi, trig.sin_theta);
        end
    end

    always_comb begin
        ax = r_sx[TW-1] ? c2e_pkg::MAG_W'(-r_sx) : r_sx[c2e_pkg::MAG_W-1:0];
        ay = r_sy[TW-1] ? c2e_pkg::MAG_W'(-r_sy) : r_sy[c2e_pkg::MAG_W-1:0];
        az = r_sz[TW-1] ? c2e_pkg::MAG_W'(-r_sz) : r_sz[c2e_pkg::MAG_W-1:0];
        priority if (ax >= ay && ax >= az) begin
            if (r_sx > 0) begin
                sel_face = c2e_pkg::FACE_RIGHT;
                sel_d    = r_sx;
                sel_nu   = -r_sz;
            end else begin
                sel_face = c2e_pkg::FACE_LEFT;
                sel_d    = -r_sx;
                sel_nu   = r_sz;
            end
            sel_nv = -r_sy;
        end else if (ay >= ax && ay >= az) begin
            sel_face = (r_sy > 0) ? c2e_pkg::FACE_TOP : c2e_pkg::FACE_BOTTOM;
            sel_d    = r_sy;
            sel_nu   = r_sx;
            sel_nv   = r_sz;
        end else begin
            sel_face = (r_sz > 0) ? c2e_pkg::FACE_FRONT : c2e_pkg::FACE_BACK;
            sel_d    = r_sz;
            sel_nu   = r_sx;
            sel_nv   = r_sy;
        end
        if (sel_d < 0) begin
            sel_d  = -sel_d;
            sel_nu = -sel_nu;
            sel_nv = -sel_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
            r_m_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_q_v;
            r_m_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side.face     <= sel_face;
            r_f_side.null_dir <= (sel_d == 0);
            r_f_den           <= {sel_d[TW-2:0], 1'b0};
            r_f_num_u         <= TW'(sel_nu + sel_d);
            r_f_num_v         <= TW'(sel_nv + sel_d);
            r_m_side          <= r_f_side;
            r_m_den           <= r_f_den;
            r_m_prod_u        <= r_f_num_u * r_face_width;
            r_m_prod_v        <= r_f_num_v * r_face_height;
        end
    end

    c2e_proj u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_m_v),
        .i_side   (r_m_side),
        .i_den    (r_m_den),
        .i_prod_u (r_m_prod_u),
        .i_prod_v (r_m_prod_v),
        .o_valid  (pj_v),
        .o_side   (pj_side),
        .o_quo_u  (pj_u),
        .o_quo_v  (pj_v_quo)
    );

    assign fin_u  = pj_side.null_dir ? (r_face_width >> 1) : pj_u;
    assign fin_v  = pj_side.null_dir ? (r_face_height >> 1) : pj_v_quo;
    assign fin_ok = (fin_u < r_face_width) && (fin_v < r_face_height)
                 && (32'(fin_u) <= COORD_MAX) && (32'(fin_v) <= COORD_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= pj_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_face <= pj_side.face;
            r_o_u    <= fin_ok ? fin_u : '0;
            r_o_v    <= fin_ok ? fin_v : '0;
            r_o_ok   <= fin_ok;
        end
    end

    assign o_map.valid    = r_o_valid;
    assign o_map.face     = r_o_face;
    assign o_map.face_u   = r_o_u;
    assign o_map.face_v   = r_o_v;
    assign o_map.in_range = r_o_ok;
endmodule
`default_nettype wire

>>> verif/c2e_lookup_checker.sv
`timescale 1ns / 1ps
module c2e_lookup_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [c2e_pkg::CFG_W-1:0] i_cfg_data,
    c2e_pix_if                             pix,
    c2e_map_if                             map,
    output int                             o_errors,
    output int                             o_pending
);
    localparam int ABITS = 16;
    localparam int CBITS = 13;
    localparam bit [63:0] ONE = 64'd1 << 30;
    localparam bit [63:0] TURN_MASK = (64'd1 << ABITS) - 1;
    localparam bit [63:0] QUARTER = 64'd1 << (ABITS - 2);
    localparam bit [63:0] COORD_MAX = (64'd1 << CBITS) - 1;

    typedef struct {
        logic [2:0]                  face;
        logic [c2e_pkg::COORD_W-1:0] u;
        logic [c2e_pkg::COORD_W-1:0] v;
        logic                        ok;
    } t_lookup;

    bit [63:0] pano_w, pano_h, fw, fh;
    t_lookup   lookups_due[$];

    function automatic longint turn_sin(bit [63:0] a);
        bit [63:0] q, x, x2, p, s;
        a = a & TURN_MASK;
        q = (a >> (ABITS - 2)) & 3;
        x = (a & (QUARTER - 1)) << (32 - ABITS);
        if (q[0]) begin
            x = ONE - x;
        end
        x2 = (x * x) >> 30;
        p = 64'(c2e_pkg::POLY_C9);
        for (int k = 0; k < c2e_pkg::HORNER_N; k++) begin
            p = 64'(c2e_pkg::POLY_C[k]) - ((x2 * p) >> 30);
        end
        s = (x * p) >> 30;
        if (s > ONE) begin
            s = ONE;
        end
        return (q >= 2) ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        bit [63:0] ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] face_coord(longint n, longint d, bit [63:0] size);
        bit [63:0] num;
        if (d == 0) begin
            return size >> 1;
        end
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        num = n + d;
        return (num * size) / (64'(d) * 2);
    endfunction

    function automatic t_lookup map_pixel(bit [63:0] x, bit [63:0] y);
        bit [63:0]      w, h, theta, phi, u, v;
        longint         cp, sx, sy, sz, ax, ay, az, d, nu, nv;
        c2e_pkg::t_face f;
        t_lookup        r;
        w = (pano_w != 0) ? pano_w : 1;
        h = (pano_h != 0) ? pano_h : 1;
        theta = ((x << ABITS) / w) & TURN_MASK;
        phi = (((y << (ABITS - 1)) / h) - QUARTER) & TURN_MASK;
        cp = turn_sin(phi + QUARTER);
        sx = fix_mul(cp, turn_sin(theta + QUARTER));
        sy = turn_sin(phi);
        sz = fix_mul(cp, turn_sin(theta));
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        if (ax >= ay && ax >= az) begin
            if (sx > 0) begin
                f = c2e_pkg::FACE_RIGHT; d = sx; nu = -sz; nv = -sy;
            end else begin
                f = c2e_pkg::FACE_LEFT; d = -sx; nu = sz; nv = -sy;
            end
        end else if (ay >= ax && ay >= az) begin
            f = (sy > 0) ? c2e_pkg::FACE_TOP : c2e_pkg::FACE_BOTTOM;
            d = sy; nu = sx; nv = sz;
        end else begin
            f = (sz > 0) ? c2e_pkg::FACE_FRONT : c2e_pkg::FACE_BACK;
            d = sz; nu = sx; nv = sy;
        end
        u = face_coord(nu, d, fw);
        v = face_coord(nv, d, fh);
        r.face = f;
        r.ok = (u < fw) && (v < fh) && (u <= COORD_MAX) && (v <= COORD_MAX);
        r.u = r.ok ? u[c2e_pkg::COORD_W-1:0] : '0;
        r.v = r.ok ? v[c2e_pkg::COORD_W-1:0] : '0;
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            pano_w = 64'(c2e_pkg::RST_OUT_WIDTH);
            pano_h = 64'(c2e_pkg::RST_OUT_HEIGHT);
            fw = 64'(c2e_pkg::RST_FACE_WIDTH);
            fh = 64'(c2e_pkg::RST_FACE_HEIGHT);
        end else begin
            if (pix.valid && pix.ready) begin
                lookups_due.push_back(map_pixel(64'(pix.out_x), 64'(pix.out_y)));
            end
            if (map.valid && map.ready) begin
                if (lookups_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: unexpected result face=%0d u=%0d v=%0d ok=%0b",
                                 $time, map.face, map.face_u, map.face_v,
                                 map.in_range);
                    end
                end else begin
                    want = lookups_due.pop_front();
                    if (map.face !== want.face || map.face_u !== want.u ||
                        map.face_v !== want.v || map.in_range !== want.ok) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display({"%0t: mismatch exp face=%0d u=%0d v=%0d ok=%0b, ",
                                      "got face=%0d u=%0d v=%0d ok=%0b"},
                                     $time, want.face, want.u, want.v, want.ok,
                                     map.face, map.face_u, map.face_v, map.in_range);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (c2e_pkg::t_cfg_idx'(i_cfg_idx))
                    c2e_pkg::CFG_OUT_WIDTH: pano_w = 64'(i_cfg_data);
                    c2e_pkg::CFG_OUT_HEIGHT: pano_h = 64'(i_cfg_data);
                    c2e_pkg::CFG_FACE_WIDTH: fw = 64'(i_cfg_data[c2e_pkg::FSIZE_W-1:0]);
                    c2e_pkg::CFG_FACE_HEIGHT: fh = 64'(i_cfg_data[c2e_pkg::FSIZE_W-1:0]);
                    default: ;
                endcase
            end
        end
        o_pending = lookups_due.size();
    end
endmodule

>>> verif/tb_cubemap_to_equirect_lookup_core.sv
`timescale 1ns / 1ps
module tb_cubemap_to_equirect_lookup_core;
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_idx = '0;
    logic [c2e_pkg::CFG_W-1:0] cfg_data = '0;
    int                        errors;
    int                        pending;
    bit                        steady_ready = 1'b0;
    int                        pano_w = 24000;
    int                        pano_h = 12000;

    c2e_pix_if pix ();
    c2e_map_if map ();

    cubemap_to_equirect_lookup_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .o_map(map),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    c2e_lookup_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .pix(pix), .map(map), .o_errors(errors), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        pix.valid = 1'b0;
        pix.out_x = '0;
        pix.out_y = '0;
        map.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    always @(negedge i_clk) begin
        int hold;
        if (hold > 0) begin
            hold--;
        end else if (steady_ready) begin
            map.ready = 1'b1;
        end else begin
            hold = gap_len();
            map.ready = (hold == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_pixel(int x, int y);
        int g;
        pix.valid = 1'b1;
        pix.out_x = x[c2e_pkg::PIX_W-1:0];
        pix.out_y = y[c2e_pkg::PIX_W-1:0];
        do @(posedge i_clk); while (!pix.ready);
        @(negedge i_clk);
        g = steady_ready ? 0 : gap_len();
        if (g > 0) begin
            pix.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        pix.valid = 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic write_reg(c2e_pkg::t_cfg_idx idx, int val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val[c2e_pkg::CFG_W-1:0];
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == c2e_pkg::CFG_OUT_WIDTH) begin
            pano_w = val;
        end
        if (idx == c2e_pkg::CFG_OUT_HEIGHT) begin
            pano_h = val;
        end
    endtask

    task automatic set_sizes(int w, int h, int fw, int fh);
        drain();
        write_reg(c2e_pkg::CFG_OUT_WIDTH, w);
        write_reg(c2e_pkg::CFG_OUT_HEIGHT, h);
        write_reg(c2e_pkg::CFG_FACE_WIDTH, fw);
        write_reg(c2e_pkg::CFG_FACE_HEIGHT, fh);
    endtask

    task automatic random_pixels(int n);
        int w, h;
        w = (pano_w > 0) ? pano_w : 1;
        h = (pano_h > 0) ? pano_h : 1;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                send_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            end else begin
                send_pixel($urandom_range(0, 32767), $urandom_range(0, 32767));
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Poles, seams, quarter turns and wrap beyond the panorama at reset sizes.
        send_pixel(0, 0);
        send_pixel(0, 6000);
        send_pixel(23999, 11999);
        send_pixel(6000, 6000);
        send_pixel(12000, 6000);
        send_pixel(18000, 6000);
        send_pixel(3000, 3000);
        send_pixel(3000, 9000);
        send_pixel(9000, 4500);
        send_pixel(32767, 32767);
        send_pixel(24000, 12000);
        send_pixel(21000, 7500);
        set_sizes(1, 1, 1, 1);
        send_pixel(0, 0);
        send_pixel(32767, 32767);
        set_sizes(0, 0, 0, 0);
        send_pixel(0, 0);
        send_pixel(21845, 10922);
        set_sizes(32767, 32767, 8191, 8191);
        send_pixel(0, 16383);
        send_pixel(32766, 32766);
        send_pixel(4095, 8191);
        send_pixel(16384, 24575);

        set_sizes(24000, 12000, 1024, 1024);
        random_pixels(200);
        drain();
        steady_ready = 1'b1;
        random_pixels(100);
        steady_ready = 1'b0;
        set_sizes(360, 180, 64, 48);
        random_pixels(200);
        set_sizes(32767, 32767, 8191, 8191);
        random_pixels(150);
        set_sizes(1, 1, 1, 1);
        random_pixels(60);
        set_sizes(0, 0, 0, 0);
        random_pixels(60);
        set_sizes($urandom_range(1, 32767), $urandom_range(1, 32767),
                  $urandom_range(1, 8191), $urandom_range(1, 8191));
        random_pixels(150);
        set_sizes(1000, 20000, 8191, 1);
        random_pixels(100);
        drain();
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_cubemap_to_equirect_lookup_core: clean");
        end else begin
            $display("tb_cubemap_to_equirect_lookup_core: errors");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_cubemap_to_equirect_lookup_core: errors");
        $finish;
    end
endmodule

>>> cubemap_to_equirect_lookup_core.f
src/c2e_pkg.sv
src/c2e_pix_if.sv
src/c2e_map_if.sv
src/c2e_angle.sv
src/c2e_trig.sv
src/c2e_proj.sv
src/cubemap_to_equirect_lookup_core.sv
verif/c2e_lookup_checker.sv
verif/tb_cubemap_to_equirect_lookup_core.sv
